[rtl/core/essf_pkg.sv]
// shared constants and register index codes for the euler state-space filter
package essf_pkg;

    // sample and coefficient word width, q16.16
    localparam int Q_W = 32;
    // fraction bits of the q16.16 format
    localparam int FRAC_W = 16;
    // full product width and width after dropping the fraction bits
    localparam int FULL_W = 2 * Q_W;
    localparam int PROD_W = FULL_W - FRAC_W;
    // time step register width, unsigned
    localparam int TS_W = 31;
    // number of coefficient slots per polynomial
    localparam int NUM_COEF = 3;
    localparam int COEF_IDX_W = $clog2(NUM_COEF);
    // default filter order
    localparam int ORDER_DEFAULT = 3;
    // configuration index width
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEN_A       = 3'd0,
        REG_DEN_B       = 3'd1,
        REG_DEN_C       = 3'd2,
        REG_NUM_A       = 3'd3,
        REG_NUM_B       = 3'd4,
        REG_NUM_C       = 3'd5,
        REG_DIRECT_GAIN = 3'd6,
        REG_TIME_STEP   = 3'd7
    } reg_idx_t;

    // reset value of the direct gain, 1.0 in q16.16
    localparam logic signed [Q_W-1:0] DIRECT_GAIN_RESET = Q_W'(1 << FRAC_W);

endpackage

[rtl/core/essf_in_if.sv]
// input sample channel: valid/ready handshake carrying one sample word
interface essf_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [essf_pkg::Q_W-1:0]        sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

[rtl/core/essf_out_if.sv]
// output sample channel: valid/ready handshake carrying one sample word
interface essf_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [essf_pkg::Q_W-1:0]        sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

[rtl/core/essf_mul.sv]
// shared q16.16 multiplier: registered operands, registered product, cut to q32.16
module essf_mul (
    input  logic                                   clk,
    input  logic signed [essf_pkg::Q_W-1:0]        op_a,
    input  logic signed [essf_pkg::Q_W-1:0]        op_b,
    output logic signed [essf_pkg::PROD_W-1:0]     prod
);

    logic signed [essf_pkg::Q_W-1:0]    a_reg;
    logic signed [essf_pkg::Q_W-1:0]    b_reg;
    logic signed [essf_pkg::FULL_W-1:0] full_reg;

    // operand stage then product stage
    always_ff @(posedge clk)
    begin
        a_reg    <= op_a;
        b_reg    <= op_b;
        full_reg <= a_reg * b_reg;
    end

    // dropping the low fraction bits floors toward minus infinity
    assign prod = full_reg[essf_pkg::FULL_W-1:essf_pkg::FRAC_W];

endmodule

[rtl/core/euler_state_space_filter.sv]
// top level of the forward euler state-space filter with one shared multiplier
//
//  channel    dir   handshake              word
//  ---------  ----  ---------------------  -------------------------------
//  in_stream  in    valid / ready          sample_in, signed q16.16
//  out_stream out   valid / ready          sample_out, signed q16.16
//  cfg        in    cfg_we (no wait)       cfg_addr index, cfg_data value
//
// every word issues 3*ORDER+1 products in turn, the drive product held for the settled
// denominator sum, through two multiplier register stages, then passes the done state
// and returns to idle once the output register is free.
// rst_n clears the state vector and loads the register reset values.
// in_ready is high only while idle; a finished word waits in the output
// register, so a new word is taken while the previous result is unread.
module euler_state_space_filter #(
    parameter int ORDER = essf_pkg::ORDER_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [essf_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [essf_pkg::Q_W-1:0]           cfg_data,
    essf_in_if.sink                            in_stream,
    essf_out_if.source                         out_stream
);

    localparam int Q_W      = essf_pkg::Q_W;
    localparam int PROD_W   = essf_pkg::PROD_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int WIDE_W   = ACC_W + 1;
    localparam int IDX_W    = essf_pkg::COEF_IDX_W;
    // drive product waits until the denominator sum has settled
    localparam int DRIVE_STEP = (3 * ORDER > 2 * ORDER + 3) ? 3 * ORDER : 2 * ORDER + 3;
    localparam int LAST_STEP  = DRIVE_STEP + 2;
    localparam int STEP_W     = $clog2(LAST_STEP + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } fsm_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DIRECT,
        OP_NUM,
        OP_DEN,
        OP_PROP,
        OP_DRIVE
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [IDX_W-1:0]  idx;
    } op_t;

    // schedule: direct term, num/den pairs, state propagation, then drive
    function automatic op_t op_at(input logic [STEP_W-1:0] s);
        int  t;
        op_t o;
        t      = int'(s);
        o.kind = OP_NONE;
        o.idx  = '0;
        if (t == 0)
        begin
            o.kind = OP_DIRECT;
        end
        else if (t <= 2 * ORDER)
        begin
            if (s[0])
            begin
                o.kind = OP_NUM;
                o.idx  = IDX_W'((t - 1) >> 1);
            end
            else
            begin
                o.kind = OP_DEN;
                o.idx  = IDX_W'((t - 2) >> 1);
            end
        end
        else if (t <= 3 * ORDER - 1)
        begin
            o.kind = OP_PROP;
            o.idx  = IDX_W'(t - 2 * ORDER);
        end
        else if (t == DRIVE_STEP)
        begin
            o.kind = OP_DRIVE;
        end
        return o;
    endfunction

    // clamp to the signed q16.16 range
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v[WIDE_W-1:Q_W-1] == '0 || v[WIDE_W-1:Q_W-1] == '1)
        begin
            r = v[Q_W-1:0];
        end
        else if (v[WIDE_W-1])
        begin
            r = {1'b1, {(Q_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(Q_W-1){1'b1}}};
        end
        return r;
    endfunction

    // control and configuration registers
    fsm_t                           fsm_reg, fsm_next;
    logic [STEP_W-1:0]              step_reg, step_next;
    op_t                            pipe0_reg, pipe1_reg;
    op_t                            issue_op;
    logic                           out_valid_reg, out_valid_next;
    logic signed [Q_W-1:0]          den_coef_reg [essf_pkg::NUM_COEF];
    logic signed [Q_W-1:0]          num_coef_reg [essf_pkg::NUM_COEF];
    logic signed [Q_W-1:0]          direct_gain_reg;
    logic [essf_pkg::TS_W-1:0]      time_step_reg;
    logic signed [Q_W-1:0]          state_reg [ORDER];
    logic signed [Q_W-1:0]          state_next [ORDER];

    // datapath registers
    logic signed [Q_W-1:0]          x_reg;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;
    logic signed [ACC_W-1:0]        dacc_reg, dacc_next;
    logic signed [Q_W-1:0]          out_data_reg;

    // multiplier hookup
    logic signed [Q_W-1:0]          mul_a, mul_b;
    logic signed [PROD_W-1:0]       prod;
    logic signed [Q_W-1:0]          state_sel;
    logic [IDX_W-1:0]               rd_idx;
    logic signed [Q_W-1:0]          drive;
    logic [IDX_W-1:0]               wr_idx;
    logic signed [Q_W-1:0]          wr_val;
    logic                           wr_en;
    logic                           in_fire;
    logic                           out_free;

    assign in_fire  = in_stream.valid && in_stream.ready;
    assign out_free = !out_valid_reg || out_stream.ready;

    assign in_stream.ready       = (fsm_reg == S_IDLE);
    assign out_stream.valid      = out_valid_reg;
    assign out_stream.sample_out = out_data_reg;

    essf_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // operation issued this cycle
    assign issue_op = (fsm_reg == S_RUN) ? op_at(step_reg) : op_t'{OP_NONE, '0};

    // state read port for the issued operation
    always_comb
    begin
        rd_idx    = (issue_op.kind == OP_PROP) ? issue_op.idx - IDX_W'(1) : issue_op.idx;
        state_sel = '0;
        for (int k = 0; k < ORDER; k++)
        begin
            if (rd_idx == IDX_W'(k))
            begin
                state_sel = state_reg[k];
            end
        end
    end

    // euler drive: input minus denominator dot product, clamped
    assign drive = sat_q(WIDE_W'(x_reg) - WIDE_W'(dacc_reg));

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (issue_op.kind)
            OP_DIRECT:
            begin
                mul_a = direct_gain_reg;
                mul_b = x_reg;
            end
            OP_NUM:
            begin
                mul_a = num_coef_reg[issue_op.idx];
                mul_b = state_sel;
            end
            OP_DEN:
            begin
                mul_a = den_coef_reg[issue_op.idx];
                mul_b = state_sel;
            end
            OP_PROP:
            begin
                mul_a = {1'b0, time_step_reg};
                mul_b = state_sel;
            end
            OP_DRIVE:
            begin
                mul_a = {1'b0, time_step_reg};
                mul_b = drive;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // retire the product of the operation carried through pipe0_reg and pipe1_reg, in step with the multiplier
    always_comb
    begin
        acc_next  = acc_reg;
        dacc_next = dacc_reg;
        wr_en     = 1'b0;
        wr_idx    = pipe1_reg.idx;
        wr_val    = '0;
        unique case (pipe1_reg.kind)
            OP_DIRECT: acc_next  = ACC_W'(prod);
            OP_NUM:    acc_next  = acc_reg + ACC_W'(prod);
            OP_DEN:    dacc_next = dacc_reg + ACC_W'(prod);
            OP_PROP,
            OP_DRIVE:
            begin
                wr_en = 1'b1;
                if (pipe1_reg.kind == OP_DRIVE)
                begin
                    wr_idx = '0;
                end
                wr_val = '0;
                for (int k = 0; k < ORDER; k++)
                begin
                    if (wr_idx == IDX_W'(k))
                    begin
                        wr_val = sat_q(WIDE_W'(state_reg[k]) + WIDE_W'(prod));
                    end
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
        if (in_fire)
        begin
            dacc_next = '0;
        end
    end

    // state vector update
    always_comb
    begin
        for (int k = 0; k < ORDER; k++)
        begin
            state_next[k] = (wr_en && wr_idx == IDX_W'(k)) ? wr_val : state_reg[k];
        end
    end

    // sequencer
    always_comb
    begin
        fsm_next       = fsm_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_stream.ready;
        unique case (fsm_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    fsm_next  = S_RUN;
                    step_next = '0;
                end
            end
            S_RUN:
            begin
                if (step_reg == STEP_W'(LAST_STEP))
                begin
                    fsm_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    fsm_next       = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    // control, configuration and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg         <= S_IDLE;
            step_reg        <= '0;
            pipe0_reg       <= op_t'{OP_NONE, '0};
            pipe1_reg       <= op_t'{OP_NONE, '0};
            out_valid_reg   <= 1'b0;
            direct_gain_reg <= essf_pkg::DIRECT_GAIN_RESET;
            time_step_reg   <= '0;
            for (int k = 0; k < essf_pkg::NUM_COEF; k++)
            begin
                den_coef_reg[k] <= '0;
                num_coef_reg[k] <= '0;
            end
            for (int k = 0; k < ORDER; k++)
            begin
                state_reg[k] <= '0;
            end
        end
        else
        begin
            fsm_reg       <= fsm_next;
            step_reg      <= step_next;
            pipe0_reg     <= issue_op;
            pipe1_reg     <= pipe0_reg;
            out_valid_reg <= out_valid_next;
            for (int k = 0; k < ORDER; k++)
            begin
                state_reg[k] <= state_next[k];
            end
            // register writes
            if (cfg_we)
            begin
                unique case (essf_pkg::reg_idx_t'(cfg_addr))
                    essf_pkg::REG_DEN_A:       den_coef_reg[0] <= cfg_data;
                    essf_pkg::REG_DEN_B:       den_coef_reg[1] <= cfg_data;
                    essf_pkg::REG_DEN_C:       den_coef_reg[2] <= cfg_data;
                    essf_pkg::REG_NUM_A:       num_coef_reg[0] <= cfg_data;
                    essf_pkg::REG_NUM_B:       num_coef_reg[1] <= cfg_data;
                    essf_pkg::REG_NUM_C:       num_coef_reg[2] <= cfg_data;
                    essf_pkg::REG_DIRECT_GAIN: direct_gain_reg <= cfg_data;
                    essf_pkg::REG_TIME_STEP:   time_step_reg   <= cfg_data[essf_pkg::TS_W-1:0];
                    default:                   time_step_reg   <= time_step_reg;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        dacc_reg <= dacc_next;
        if (in_fire)
        begin
            x_reg <= in_stream.sample_in;
        end
        if (fsm_reg == S_DONE && out_free)
        begin
            out_data_reg <= sat_q(WIDE_W'(acc_reg));
        end
    end

endmodule
